### design/wmf_pkg.sv
package wmf_pkg;

	localparam int MAX_WIDTH = 9;
	localparam int MAX_COLS  = 1024;
	localparam int MAX_ROWS  = 1024;

	localparam int PIX_W  = 8;
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int CW     = $clog2(MAX_COLS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int NCELL  = MAX_WIDTH * MAX_WIDTH;
	localparam int NW     = $clog2(NCELL);
	localparam int HW     = $clog2(NCELL / 2 + 1);
	localparam int LSW    = (MAX_WIDTH - 1) * PIX_W;
	localparam int TOP_WIDTH = (MAX_WIDTH % 2 == 1) ? MAX_WIDTH : MAX_WIDTH - 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS   = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SORT,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic ins;
		logic drn;
	} cell_ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] val;
		logic             vld;
		logic             gt;
	} cell_out_t;

	function automatic logic [WW-1:0] eff_width(input logic [3:0] r);
		logic [4:0] t;
		t = (r == 4'd0) ? 5'd1 : {1'b0, r};
		if (!t[0]) t = t + 5'd1;
		if (int'(t) > TOP_WIDTH) t = 5'(TOP_WIDTH);
		return WW'(t);
	endfunction

	function automatic logic [CW:0] eff_cols(input logic [CFG_DATA_W-1:0] v);
		if (v == '0) return (CW+1)'(1);
		if (int'(v) > MAX_COLS) return (CW+1)'(MAX_COLS);
		return (CW+1)'(v);
	endfunction

	function automatic logic [RW:0] eff_rows(input logic [CFG_DATA_W-1:0] v);
		if (v == '0) return (RW+1)'(1);
		if (int'(v) > MAX_ROWS) return (RW+1)'(MAX_ROWS);
		return (RW+1)'(v);
	endfunction

endpackage

### design/wmf_sort_cell.sv
module wmf_sort_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wmf_pkg::cell_ctl_t          ctl,
	input  logic [wmf_pkg::PIX_W-1:0]   v,
	input  wmf_pkg::cell_out_t          prev,
	input  wmf_pkg::cell_out_t          next,
	output wmf_pkg::cell_out_t          co
);

	logic [wmf_pkg::PIX_W-1:0] val_q;
	logic                      vld_q;
	logic                      gt;

	// an empty cell counts as larger than anything
	assign gt = !vld_q || (val_q > v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.ins) begin
			if (prev.gt) begin
				val_q <= prev.val;
				vld_q <= prev.vld;
			end else if (gt) begin
				val_q <= v;
				vld_q <= 1'b1;
			end
		end else if (ctl.drn) begin
			val_q <= next.val;
			vld_q <= next.vld;
		end
	end

	assign co.val = val_q;
	assign co.vld = vld_q;
	assign co.gt  = gt;

endmodule

### design/wmf_line_store.sv
module wmf_line_store (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [wmf_pkg::CW-1:0]      rd_addr,
	output logic [wmf_pkg::LSW-1:0]     rd_data,
	input  logic                        wr_en,
	input  logic [wmf_pkg::CW-1:0]      wr_addr,
	input  logic [wmf_pkg::LSW-1:0]     wr_data
);

	logic [wmf_pkg::LSW-1:0] mem [wmf_pkg::MAX_COLS];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule

### design/window_median_filter_core.sv
// Flow: an accepted item is read into the window (ST_READ); a window outside the frame goes straight
// to ST_DONE, one inside is scanned through the sort chain (ST_SORT) and drained to its median (ST_DRAIN).
// Throughput: one item at a time; the next item is taken as soon as the result sits in the
// output register, so the rate is set by the scan and drain of the insertion cell chain and by out_stall.
// Reset: asynchronous, active low; afterwards the line store is zeroed one column a cycle,
// all MAX_COLS (1024) columns, and no item is accepted until the clear is done.
module window_median_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          pixel,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          median_value,
	output logic                                inside_res,
	output logic                                frame_end,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wmf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wmf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int MW = wmf_pkg::MAX_WIDTH;
	localparam int NC = wmf_pkg::NCELL;
	localparam int CW = wmf_pkg::CW;
	localparam int RW = wmf_pkg::RW;

	wmf_pkg::state_t state_q, state_d;

	logic [3:0]                     wsel_q;
	logic [wmf_pkg::CFG_DATA_W-1:0] cols_q, rows_q;
	logic [CW-1:0]                  col_q;
	logic [RW-1:0]                  row_q;
	logic [CW-1:0]                  clr_addr_q;

	logic [7:0]                     px_q;
	logic [CW-1:0]                  c_q;
	logic                           inside_q, last_q;
	logic [wmf_pkg::WW-1:0]         w_q;
	logic [wmf_pkg::HW-1:0]         half_q;

	logic [7:0]                     win_q [MW][MW];
	logic [7:0]                     win_d [MW][MW];
	logic [7:0]                     scan_q [NC];
	logic [wmf_pkg::NW-1:0]         scan_cnt_q;
	logic [wmf_pkg::WW-1:0]         sx_q, sy_q;

	logic                           out_valid_q, inside_out_q, frame_end_q;
	logic [7:0]                     median_q;

	logic [wmf_pkg::WW-1:0]         w_eff;
	logic [CW:0]                    cols_eff;
	logic [RW:0]                    rows_eff;
	logic [CW-1:0]                  c;
	logic [RW-1:0]                  r;
	logic                           accept, load_out, scan_end;
	logic [2*wmf_pkg::WW-1:0]       nsq;

	logic                           mem_we;
	logic [CW-1:0]                  mem_waddr;
	logic [wmf_pkg::LSW-1:0]        mem_wdata, mem_rdata;

	wmf_pkg::cell_ctl_t             ctl;
	wmf_pkg::cell_out_t             co [NC];

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		w_eff    = wmf_pkg::eff_width(wsel_q);
		cols_eff = wmf_pkg::eff_cols(cols_q);
		rows_eff = wmf_pkg::eff_rows(rows_q);
		c = ({1'b0, col_q} >= cols_eff) ? CW'(cols_eff - (CW+1)'(1)) : col_q;
		r = ({1'b0, row_q} >= rows_eff) ? RW'(rows_eff - (RW+1)'(1)) : row_q;
		nsq = w_eff * w_eff;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q <= 4'd1;
			cols_q <= wmf_pkg::CFG_DATA_W'(512);
			rows_q <= wmf_pkg::CFG_DATA_W'(512);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wmf_pkg::CFG_WINDOW_WIDTH: wsel_q <= cfg_data[3:0];
				wmf_pkg::CFG_IMAGE_COLS:   cols_q <= cfg_data;
				wmf_pkg::CFG_IMAGE_ROWS:   rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (({1'b0, c} + (CW+1)'(1)) >= cols_eff) begin
				col_q <= '0;
				row_q <= (({1'b0, r} + (RW+1)'(1)) >= rows_eff) ? '0 : r + RW'(1);
			end else begin
				col_q <= c + CW'(1);
				row_q <= r;
			end
		end
	end

	// per-item context
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q     <= pixel;
			c_q      <= c;
			w_q      <= w_eff;
			inside_q <= (int'(r) + 1 >= int'(w_eff)) && (int'(c) + 1 >= int'(w_eff));
			last_q   <= ({1'b0, r} == rows_eff - (RW+1)'(1)) &&
			            ({1'b0, c} == cols_eff - (CW+1)'(1));
			half_q   <= wmf_pkg::HW'(nsq >> 1);
		end else if (state_q == wmf_pkg::ST_DRAIN) begin
			half_q   <= half_q - wmf_pkg::HW'(1);
		end
	end

	wmf_line_store u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c),
		.rd_data (mem_rdata),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata)
	);

	// shift window one column, new column enters at x = 0
	always_comb begin
		for (int y = 0; y < MW; y++) begin
			for (int x = 1; x < MW; x++) begin
				win_d[y][x] = win_q[y][x-1];
			end
		end
		win_d[0][0] = px_q;
		for (int k = 0; k < MW - 1; k++) begin
			win_d[k+1][0] = mem_rdata[k*8 +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < MW; y++) begin
				for (int x = 0; x < MW; x++) begin
					win_q[y][x] <= '0;
				end
			end
		end else if (state_q == wmf_pkg::ST_READ) begin
			win_q <= win_d;
		end
	end

	// scan line: load the new window, then advance one pixel per cycle
	always_ff @(posedge clk) begin
		if (state_q == wmf_pkg::ST_READ) begin
			for (int y = 0; y < MW; y++) begin
				for (int x = 0; x < MW; x++) begin
					scan_q[y*MW + x] <= win_d[y][x];
				end
			end
		end else if (state_q == wmf_pkg::ST_SORT) begin
			for (int i = 0; i < NC - 1; i++) begin
				scan_q[i] <= scan_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			clr_addr_q <= '0;
		end else begin
			if (state_q == wmf_pkg::ST_READ) begin
				scan_cnt_q <= '0;
				sx_q       <= '0;
				sy_q       <= '0;
			end else if (state_q == wmf_pkg::ST_SORT) begin
				scan_cnt_q <= scan_cnt_q + wmf_pkg::NW'(1);
				if (sx_q == wmf_pkg::WW'(MW - 1)) begin
					sx_q <= '0;
					sy_q <= sy_q + wmf_pkg::WW'(1);
				end else begin
					sx_q <= sx_q + wmf_pkg::WW'(1);
				end
			end
			if (state_q == wmf_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + CW'(1);
		end
	end

	assign scan_end = (scan_cnt_q == wmf_pkg::NW'(NC - 1));

	// insertion sort chain
	for (genvar i = 0; i < NC; i++) begin : g_cell
		wmf_pkg::cell_out_t prev_i, next_i;
		if (i == 0) begin : g_head
			assign prev_i = '{val: '0, vld: 1'b1, gt: 1'b0};
		end else begin : g_body
			assign prev_i = co[i-1];
		end
		if (i == NC - 1) begin : g_tail
			assign next_i = '0;
		end else begin : g_link
			assign next_i = co[i+1];
		end
		wmf_sort_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.v      (scan_q[0]),
			.prev   (prev_i),
			.next   (next_i),
			.co     (co[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wmf_pkg::ST_CLEAR: if (clr_addr_q == CW'(wmf_pkg::MAX_COLS - 1)) state_d = wmf_pkg::ST_IDLE;
			wmf_pkg::ST_IDLE:  if (accept) state_d = wmf_pkg::ST_READ;
			wmf_pkg::ST_READ:  state_d = inside_q ? wmf_pkg::ST_SORT : wmf_pkg::ST_DONE;
			wmf_pkg::ST_SORT: begin
				if (scan_end) state_d = (half_q == '0) ? wmf_pkg::ST_DONE : wmf_pkg::ST_DRAIN;
			end
			wmf_pkg::ST_DRAIN: if (half_q == wmf_pkg::HW'(1)) state_d = wmf_pkg::ST_DONE;
			wmf_pkg::ST_DONE:  if (!out_valid_q || !out_stall) state_d = wmf_pkg::ST_IDLE;
			default:           state_d = wmf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= wmf_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	// state outputs
	always_comb begin
		in_stall  = (state_q != wmf_pkg::ST_IDLE);
		mem_we    = 1'b0;
		mem_waddr = c_q;
		mem_wdata = {mem_rdata[wmf_pkg::LSW-9:0], px_q};
		ctl       = '0;
		load_out  = 1'b0;
		unique case (state_q)
			wmf_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			wmf_pkg::ST_IDLE: ;
			wmf_pkg::ST_READ: begin
				mem_we  = 1'b1;
				ctl.clr = 1'b1;
			end
			wmf_pkg::ST_SORT:  ctl.ins = (sx_q < w_q) && (sy_q < w_q);
			wmf_pkg::ST_DRAIN: ctl.drn = 1'b1;
			wmf_pkg::ST_DONE:  load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			median_q     <= inside_q ? co[0].val : '0;
			inside_out_q <= inside_q;
			frame_end_q  <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_value = median_q;
	assign inside_res   = inside_out_q;
	assign frame_end    = frame_end_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("item accepted while previous item in flight");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wmf_pkg::ST_CLEAR) |-> in_stall)
		else $error("input open during line store clear");

	a_chain_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		co[1].vld |-> (co[0].vld && (co[0].val <= co[1].val)))
		else $error("sort chain out of order");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !inside_res) |-> (median_value == '0))
		else $error("nonzero result for window outside frame");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	typedef struct {
		logic [7:0] median;
		logic       in_frame;
		logic       last;
	} median_exp_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     pixel;
	logic                           out_valid;
	logic                           out_stall;
	logic [7:0]                     median_value;
	logic                           inside_res;
	logic                           frame_end;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data;

	window_median_filter_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.median_value(median_value), .inside_res(inside_res), .frame_end(frame_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [7:0]  rows_store [wmf_pkg::MAX_WIDTH-1][wmf_pkg::MAX_COLS];
	logic [7:0]  win [wmf_pkg::MAX_WIDTH][wmf_pkg::MAX_WIDTH];
	int          row_pos, col_pos;
	logic [3:0]  reg_width;
	logic [10:0] reg_cols, reg_rows;

	median_exp_t pending_medians[$];
	int          errors;
	int          mismatches;
	int          items_sent;
	bit          in_gaps_on, out_gaps_on;

	always #5 clk = ~clk;

	function automatic int side_of(logic [3:0] r);
		int w;
		w = (r == 0) ? 1 : int'(r);
		if (w % 2 == 0) w++;
		if (w > wmf_pkg::TOP_WIDTH) w = wmf_pkg::TOP_WIDTH;
		return w;
	endfunction

	function automatic int clamp_size(logic [10:0] v, int maxv);
		if (v == 0) return 1;
		if (int'(v) > maxv) return maxv;
		return int'(v);
	endfunction

	task automatic predict_median(logic [7:0] px);
		int w, cols, rows, r, c, n;
		int vals[$];
		median_exp_t e;
		w = side_of(reg_width);
		cols = clamp_size(reg_cols, wmf_pkg::MAX_COLS);
		rows = clamp_size(reg_rows, wmf_pkg::MAX_ROWS);
		r = row_pos;
		c = col_pos;
		if (c >= cols) c = cols - 1;
		if (r >= rows) r = rows - 1;
		// shift window, new column enters at x = 0 with current row on top
		for (int y = 0; y < wmf_pkg::MAX_WIDTH; y++)
			for (int x = wmf_pkg::MAX_WIDTH - 1; x > 0; x--)
				win[y][x] = win[y][x-1];
		win[0][0] = px;
		for (int k = 0; k < wmf_pkg::MAX_WIDTH - 1; k++)
			win[k+1][0] = rows_store[k][c];
		for (int k = wmf_pkg::MAX_WIDTH - 2; k > 0; k--)
			rows_store[k][c] = rows_store[k-1][c];
		rows_store[0][c] = px;
		e.in_frame = (r + 1 >= w) && (c + 1 >= w);
		e.last = (r == rows - 1) && (c == cols - 1);
		e.median = 8'd0;
		if (e.in_frame) begin
			for (int y = 0; y < w; y++)
				for (int x = 0; x < w; x++)
					vals.push_back(int'(win[y][x]));
			vals.sort();
			n = vals.size();
			e.median = 8'(vals[n/2]);
		end
		pending_medians.push_back(e);
		if (c + 1 >= cols) begin
			col_pos = 0;
			row_pos = (r + 1 >= rows) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	task automatic send_pixel(logic [7:0] px);
		if (in_gaps_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_median(px);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_reg(logic [wmf_pkg::CFG_IDX_W-1:0] idx,
			logic [wmf_pkg::CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			wmf_pkg::CFG_WINDOW_WIDTH: reg_width = val[3:0];
			wmf_pkg::CFG_IMAGE_COLS:   reg_cols = val;
			wmf_pkg::CFG_IMAGE_ROWS:   reg_rows = val;
			default: ;
		endcase
	endtask

	task automatic set_frame(int w, int cols, int rows);
		write_reg(wmf_pkg::CFG_WINDOW_WIDTH, wmf_pkg::CFG_DATA_W'(w));
		write_reg(wmf_pkg::CFG_IMAGE_COLS, wmf_pkg::CFG_DATA_W'(cols));
		write_reg(wmf_pkg::CFG_IMAGE_ROWS, wmf_pkg::CFG_DATA_W'(rows));
	endtask

	task automatic send_frame(int n, int lo, int hi);
		repeat (n) send_pixel(8'($urandom_range(hi, lo)));
	endtask

	// reset config: width one, so each result equals its pixel
	task automatic test_defaults();
		send_pixel(8'h00);
		send_pixel(8'hff);
		send_pixel(8'h5a);
		send_pixel(8'ha5);
	endtask

	task automatic test_widths();
		// zero width, even width, full width, too wide
		set_frame(0, 4, 3);
		send_pixel(8'h00);
		send_pixel(8'hff);
		set_frame(2, 4, 4);
		send_frame(4 * 4 - 2, 0, 255);
		set_frame(9, 10, 9);
		send_frame(90, 0, 255);
		write_reg(wmf_pkg::CFG_WINDOW_WIDTH, 11'd15);
		send_frame(90, 250, 255);
		write_reg(wmf_pkg::CFG_WINDOW_WIDTH, 11'h7f8);
		send_frame(10, 0, 3);
	endtask

	task automatic test_sizes();
		// zero size acts as one: every pixel closes a frame
		set_frame(1, 0, 0);
		send_pixel(8'h80);
		send_pixel(8'h7f);
		// oversized columns saturate, one row per frame
		set_frame(1, 2047, 1);
		send_frame(1024, 0, 255);
		set_frame(3, 1024, 2047);
		send_frame(40, 0, 255);
		// unused register index is a no-op
		write_reg(2'd3, 11'h555);
		send_frame(4, 0, 255);
	endtask

	task automatic test_shrink();
		set_frame(3, 16, 16);
		send_frame(40, 0, 255);
		write_reg(wmf_pkg::CFG_IMAGE_COLS, 11'd4);
		write_reg(wmf_pkg::CFG_IMAGE_ROWS, 11'd2);
		send_frame(12, 0, 255);
	endtask

	task automatic test_random();
		int cols, rows;
		bit first;
		first = 1'b1;
		while (items_sent < 1400) begin
			// open with a stretch free of idling on both sides
			if (first || $urandom_range(99) < 20) begin
				in_gaps_on = 1'b0;
				out_gaps_on = 1'b0;
			end else begin
				in_gaps_on = 1'b1;
				out_gaps_on = 1'b1;
			end
			first = 1'b0;
			cols = ($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(40, 13);
			rows = $urandom_range(10, 1);
			set_frame($urandom_range(15, 0), cols, rows);
			if ($urandom_range(99) < 85) begin
				repeat ($urandom_range(2, 1)) begin
					if ($urandom_range(1)) send_frame(cols * rows, 0, 255);
					else send_frame(cols * rows, 100, 104);
				end
			end else begin
				// broken frame: stop part way, next config picks up mid-raster
				send_frame($urandom_range(cols * rows, 1), 0, 255);
			end
		end
		in_gaps_on = 1'b1;
		out_gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		median_exp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_medians.size() == 0) begin
				errors++;
				if (mismatches < 10)
					$display("unexpected result: median=%0d inside=%0b last=%0b",
						median_value, inside_res, frame_end);
				mismatches++;
			end else begin
				e = pending_medians.pop_front();
				if (median_value !== e.median || inside_res !== e.in_frame
						|| frame_end !== e.last) begin
					errors++;
					if (mismatches < 10)
						$display("mismatch: exp median=%0d inside=%0b last=%0b, got %0d %0b %0b",
							e.median, e.in_frame, e.last, median_value, inside_res,
							frame_end);
					mismatches++;
				end
			end
		end
		out_stall <= out_gaps_on && ($urandom_range(99) < 16);
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel = 8'd0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		mismatches = 0;
		items_sent = 0;
		in_gaps_on = 1'b1;
		out_gaps_on = 1'b1;
		foreach (rows_store[k, c]) rows_store[k][c] = 8'd0;
		foreach (win[y, x]) win[y][x] = 8'd0;
		row_pos = 0;
		col_pos = 0;
		reg_width = 4'd1;
		reg_cols = 11'd512;
		reg_rows = 11'd512;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_widths();
		test_sizes();
		test_shrink();
		test_random();

		wait_drained();
		if (pending_medians.size() != 0) errors++;
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
